// ===== sv/svpd_pkg.sv =====
// ---------------------------------------------------------------------------
// svpd_pkg
// Shared constants, codes and word types of the space vector PWM duty core.
// ---------------------------------------------------------------------------
package svpd_pkg;

  localparam int VOLT_W_DEF = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int REG_W      = 16;
  localparam int SEC_W      = 3;
  localparam int DUTY_W     = 16;
  localparam int Q_W        = 15;   // quotient bits, duty below 1.0
  localparam int REM_W      = 43;   // holds t below den * 2^15
  localparam int DEN_W      = 28;   // vdc * 3072
  localparam int BIAS_W     = 42;   // vdc * (3072 * 16384 + 1536)
  localparam int SCL_W      = 26;
  localparam int FRAC_BITS  = 24;
  localparam int FRONT_ST   = 4;
  localparam int N_STAGES   = FRONT_ST + Q_W + 1;

  localparam logic [24:0]       SQRT3_Q24  = 25'd29058991;
  localparam logic [11:0]       DEN_SCALE  = 12'd3072;
  localparam logic [SCL_W-1:0]  BIAS_SCALE = 26'd50333184;
  localparam logic [DUTY_W-1:0] DUTY_ONE   = 16'd32768;
  localparam logic [DUTY_W-1:0] DUTY_HALF  = 16'd16384;
  localparam logic [REG_W-1:0]  VDC_RST    = 16'd6144;
  localparam logic [REG_W-1:0]  PERIOD_RST = 16'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DC_BUS     = 8'd0,
    REG_PWM_PERIOD = 8'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    SAT_NONE,
    SAT_ZERO,
    SAT_ONE,
    SAT_HALF
  } sat_e;

  typedef enum logic [SEC_W-1:0] {
    SEC0, SEC1, SEC2, SEC3, SEC4, SEC5
  } sector_e;

  typedef struct packed {
    logic [DEN_W-1:0]  den;
    logic [BIAS_W-1:0] bias;
    logic              vdc_zero;
  } svpd_cfg_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    sat_e             sat;
  } phase_t;

  typedef struct packed {
    sector_e          sector;
    phase_t [2:0]     ph;
  } div_word_t;

  typedef struct packed {
    logic [SEC_W-1:0]             sector;
    logic [2:0][DUTY_W-1:0]       cmp;
    logic [2:0][DUTY_W-1:0]       volt;
  } res_t;

endpackage

// ===== sv/svpd_if.sv =====
// ---------------------------------------------------------------------------
// svpd interfaces
// Valid/ready channels: vector words in, duty words out, register writes.
// ---------------------------------------------------------------------------
interface svpd_in_if #(parameter int VOLT_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [VOLT_WIDTH-1:0] v_alpha;
  logic signed [VOLT_WIDTH-1:0] v_beta;
  modport source (output valid, v_alpha, v_beta, input ready);
  modport sink   (input valid, v_alpha, v_beta, output ready);
endinterface

interface svpd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  sector;
  logic [15:0] compare_a;
  logic [15:0] compare_b;
  logic [15:0] compare_c;
  logic [15:0] phase_volt_a;
  logic [15:0] phase_volt_b;
  logic [15:0] phase_volt_c;
  modport source (output valid, sector, compare_a, compare_b, compare_c,
                  phase_volt_a, phase_volt_b, phase_volt_c, input ready);
  modport sink   (input valid, sector, compare_a, compare_b, compare_c,
                  phase_volt_a, phase_volt_b, phase_volt_c, output ready);
endinterface

interface svpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/svpd_front.sv =====
// ---------------------------------------------------------------------------
// svpd_front
// Stages 0-3: squares and sqrt(3) product, sector and terms, mean removal,
// bias and saturation.
// ---------------------------------------------------------------------------
module svpd_front
  import svpd_pkg::*;
#(
  parameter int VOLT_WIDTH = VOLT_W_DEF
) (
  input  logic                         clk_i,
  input  logic [FRONT_ST-1:0]          en_i,
  input  logic signed [VOLT_WIDTH-1:0] v_alpha_i,
  input  logic signed [VOLT_WIDTH-1:0] v_beta_i,
  input  svpd_cfg_t                    cfg_i,
  output div_word_t                    word_o
);

  localparam int W2 = 2 * VOLT_WIDTH;
  localparam int QW = VOLT_WIDTH + 26;
  localparam int UW = VOLT_WIDTH + 27;
  localparam int NW = VOLT_WIDTH + 29;
  localparam int TW = ((NW > REM_W + 1) ? NW : REM_W + 1) + 1;

  // stage 0
  logic signed [VOLT_WIDTH-1:0] a_q, b_q;
  logic [W2-1:0]                aa2_q, bb2_q;
  logic signed [QW-1:0]         q_q;
  logic [VOLT_WIDTH-1:0]        aa, bb;
  logic signed [QW-1:0]         bq;

  assign aa = v_alpha_i[VOLT_WIDTH-1] ? (~v_alpha_i + 1'b1) : v_alpha_i;
  assign bb = v_beta_i[VOLT_WIDTH-1]  ? (~v_beta_i + 1'b1)  : v_beta_i;
  assign bq = QW'(v_beta_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q   <= v_alpha_i;
      b_q   <= v_beta_i;
      aa2_q <= W2'(aa) * W2'(aa);
      bb2_q <= W2'(bb) * W2'(bb);
      q_q   <= bq * $signed(QW'({1'b0, SQRT3_Q24}));
    end
  end

  // stage 1
  sector_e                      sec_d, sec1_q;
  logic signed [UW-1:0]         u_d [3];
  logic signed [UW-1:0]         u_q [3];
  logic [W2+1:0]                bb3;
  logic                         flat;
  logic signed [UW-1:0]         aw, qw;

  assign bb3  = (W2+2)'(bb2_q) + (W2+2)'({bb2_q, 1'b0});
  assign flat = bb3 < (W2+2)'(aa2_q);
  assign aw   = UW'(a_q) <<< FRAC_BITS;
  assign qw   = UW'(q_q);

  always_comb begin
    if (a_q == '0 && b_q == '0)  sec_d = SEC0;
    else if (flat)               sec_d = (a_q > 0) ? SEC0 : SEC3;
    else if (b_q > 0)            sec_d = (a_q > 0) ? SEC1 : SEC2;
    else                         sec_d = (a_q < 0) ? SEC4 : SEC5;
  end

  always_comb begin
    unique case (sec_d)
      SEC0: begin
        u_d[0] = aw <<< 1;  u_d[1] = aw + qw;  u_d[2] = '0;
      end
      SEC1: begin
        u_d[0] = aw - qw;   u_d[1] = qw <<< 1; u_d[2] = '0;
      end
      SEC2: begin
        u_d[0] = '0;        u_d[1] = aw + qw;  u_d[2] = -(aw <<< 1);
      end
      SEC3: begin
        u_d[0] = '0;        u_d[1] = aw - qw;  u_d[2] = qw - aw;
      end
      SEC4: begin
        u_d[0] = -(aw <<< 1); u_d[1] = '0;     u_d[2] = -aw - qw;
      end
      default: begin
        u_d[0] = qw - aw;   u_d[1] = '0;       u_d[2] = -(qw <<< 1);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sec1_q <= sec_d;
      u_q    <= u_d;
    end
  end

  // stage 2: 3u - sum = 2u - other two
  sector_e                   sec2_q;
  logic signed [NW-1:0]      num_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sec2_q <= sec1_q;
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= (NW'(u_q[i]) <<< 1) - NW'(u_q[(i+1)%3]) - NW'(u_q[(i+2)%3]);
      end
    end
  end

  // stage 3: shift origin so duty = floor(t / den), then flag the clamps
  logic signed [TW-1:0]      t [3];
  logic signed [TW-1:0]      den32k;
  div_word_t                 word_d;

  assign den32k = TW'(cfg_i.den) <<< Q_W;

  always_comb begin
    word_d.sector = sec2_q;
    for (int i = 0; i < 3; i++) begin
      t[i]               = TW'(num_q[i]) + TW'(cfg_i.bias);
      word_d.ph[i].rem   = t[i][REM_W-1:0];
      word_d.ph[i].quo   = '0;
      if (cfg_i.vdc_zero) begin
        if (num_q[i] == '0)      word_d.ph[i].sat = SAT_HALF;
        else if (num_q[i] > 0)   word_d.ph[i].sat = SAT_ONE;
        else                     word_d.ph[i].sat = SAT_ZERO;
      end else if (t[i] < 0) begin
        word_d.ph[i].sat = SAT_ZERO;
      end else if (t[i] >= den32k) begin
        word_d.ph[i].sat = SAT_ONE;
      end else begin
        word_d.ph[i].sat = SAT_NONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) word_o <= word_d;
  end

endmodule

// ===== sv/svpd_div_step.sv =====
// ---------------------------------------------------------------------------
// svpd_div_step
// One restoring division stage: one quotient bit for each of three phases.
// ---------------------------------------------------------------------------
module svpd_div_step
  import svpd_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DEN_W-1:0] den_i,
  input  div_word_t        word_i,
  output div_word_t        word_o
);

  logic [REM_W-1:0] dsh;
  div_word_t        word_d;

  assign dsh = REM_W'(den_i) << SHIFT;

  always_comb begin
    word_d = word_i;
    for (int i = 0; i < 3; i++) begin
      if (word_i.ph[i].rem >= dsh) begin
        word_d.ph[i].rem        = word_i.ph[i].rem - dsh;
        word_d.ph[i].quo[SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) word_o <= word_d;
  end

endmodule

// ===== sv/svpd_scale.sv =====
// ---------------------------------------------------------------------------
// svpd_scale
// Last stage: duty select, compare values and phase voltages.
// ---------------------------------------------------------------------------
module svpd_scale
  import svpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [REG_W-1:0] vdc_i,
  input  logic [REG_W-1:0] period_i,
  input  div_word_t        word_i,
  output res_t             res_o
);

  logic [2:0][DUTY_W-1:0] duty;
  logic [2:0][31:0]       pc, pv;
  res_t                   res_d;

  always_comb begin
    res_d.sector = word_i.sector;
    for (int i = 0; i < 3; i++) begin
      unique case (word_i.ph[i].sat)
        SAT_NONE: duty[i] = {1'b0, word_i.ph[i].quo};
        SAT_ZERO: duty[i] = '0;
        SAT_ONE:  duty[i] = DUTY_ONE;
        default:  duty[i] = DUTY_HALF;
      endcase
      pc[i] = 32'(duty[i]) * 32'(period_i) + 32'(DUTY_HALF);
      pv[i] = 32'(duty[i]) * 32'(vdc_i);
      res_d.cmp[i]  = pc[i][30:15];
      res_d.volt[i] = pv[i][30:15];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_o <= res_d;
  end

endmodule

// ===== sv/space_vector_pwm_duty_core.sv =====
// ---------------------------------------------------------------------------
// space_vector_pwm_duty_core
// Space vector PWM duty generator: alpha/beta word in, sector, compare
// values and phase voltages out.
// ---------------------------------------------------------------------------
// Takes one alpha/beta word per clock unless a held output has filled the
// pipe, and gives one result word per word, in order. The 20 register
// stages are: squares and sqrt(3) product, sector choice and
// per-sector terms, mean removal, bias and clamp flags, 15 restoring
// division stages (one quotient bit each, dividing by 3072 * bus voltage),
// and the scaling multipliers. Every stage has its own valid bit and moves
// whenever the stage after it is empty or moving, so a held output still
// lets words flow in until the bubbles are used up. Register writes are
// always taken; the divisor and bias are registered off the bus voltage
// register, so write only while the core is idle.
module space_vector_pwm_duty_core
  import svpd_pkg::*;
#(
  parameter int VOLT_WIDTH = VOLT_W_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  svpd_in_if.sink  in_s,
  svpd_out_if.source out_s,
  svpd_cfg_if.sink cfg_s
);

  // register file
  logic [REG_W-1:0] vdc_q, period_q;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdc_q    <= VDC_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_s.valid) begin
      if (cfg_s.index == REG_DC_BUS)     vdc_q    <= cfg_s.data;
      if (cfg_s.index == REG_PWM_PERIOD) period_q <= cfg_s.data;
    end
  end

  // divisor and origin shift, registered off the bus voltage
  localparam logic [DEN_W-1:0]  DEN_RST  = DEN_W'(DEN_W'(VDC_RST) * DEN_W'(DEN_SCALE));
  localparam logic [BIAS_W-1:0] BIAS_RST = BIAS_W'(BIAS_W'(VDC_RST) * BIAS_W'(BIAS_SCALE));

  svpd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.den      <= DEN_RST;
      cfg_q.bias     <= BIAS_RST;
      cfg_q.vdc_zero <= 1'b0;
    end else begin
      cfg_q.den      <= DEN_W'(vdc_q) * DEN_W'(DEN_SCALE);
      cfg_q.bias     <= BIAS_W'(vdc_q) * BIAS_W'(BIAS_SCALE);
      cfg_q.vdc_zero <= (vdc_q == '0);
    end
  end

  // valid chain, stage k loads when empty or when k+1 loads
  logic [N_STAGES-1:0] v_q, en;

  always_comb begin
    en[N_STAGES-1] = !v_q[N_STAGES-1] || out_s.ready;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_s.valid;
      for (int k = 1; k < N_STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_s.ready = en[0];

  // datapath
  div_word_t div_w [Q_W+1];
  res_t      res;

  svpd_front #(.VOLT_WIDTH(VOLT_WIDTH)) u_front (
    .clk_i     (clk_i),
    .en_i      (en[FRONT_ST-1:0]),
    .v_alpha_i (in_s.v_alpha),
    .v_beta_i  (in_s.v_beta),
    .cfg_i     (cfg_q),
    .word_o    (div_w[0])
  );

  // most significant quotient bit first
  for (genvar s = 0; s < Q_W; s++) begin : g_div
    svpd_div_step #(.SHIFT(Q_W - 1 - s)) u_step (
      .clk_i  (clk_i),
      .en_i   (en[FRONT_ST + s]),
      .den_i  (cfg_q.den),
      .word_i (div_w[s]),
      .word_o (div_w[s+1])
    );
  end

  svpd_scale u_scale (
    .clk_i    (clk_i),
    .en_i     (en[N_STAGES-1]),
    .vdc_i    (vdc_q),
    .period_i (period_q),
    .word_i   (div_w[Q_W]),
    .res_o    (res)
  );

  assign out_s.valid        = v_q[N_STAGES-1];
  assign out_s.sector       = res.sector;
  assign out_s.compare_a    = res.cmp[0];
  assign out_s.compare_b    = res.cmp[1];
  assign out_s.compare_c    = res.cmp[2];
  assign out_s.phase_volt_a = res.volt[0];
  assign out_s.phase_volt_b = res.volt[1];
  assign out_s.phase_volt_c = res.volt[2];

endmodule

// ===== sv/svpd_checker.sv =====
// ---------------------------------------------------------------------------
// svpd_checker
// Port-level checks of the space vector PWM duty core, bound to the top.
// ---------------------------------------------------------------------------
module svpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  sector_i,
  input logic [15:0] compare_a_i,
  input logic [15:0] phase_volt_a_i,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i
);

  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> sector_i <= 3'd5)
    else $error("sector out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(sector_i) && $stable(compare_a_i) && $stable(phase_volt_a_i))
    else $error("held word changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("register write refused");

endmodule

bind space_vector_pwm_duty_core svpd_checker u_svpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_s.valid),
  .out_ready_i    (out_s.ready),
  .sector_i       (out_s.sector),
  .compare_a_i    (out_s.compare_a),
  .phase_volt_a_i (out_s.phase_volt_a),
  .cfg_valid_i    (cfg_s.valid),
  .cfg_ready_i    (cfg_s.ready)
);

// ===== bench/tb_space_vector_pwm_duty_core.sv =====
// ---------------------------------------------------------------------------
// tb_space_vector_pwm_duty_core
// Self-checking bench for the SVPWM duty core: directed table then random
// alpha/beta words, checked against a bit-exact predictor.
// ---------------------------------------------------------------------------
module tb_space_vector_pwm_duty_core;
  import svpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW        = 16;
  localparam int LATENCY   = 20;
  localparam int N_RANDOM  = 380;
  localparam longint LIMIT = 400000;
  localparam longint SQ3   = 64'sd29058991;

  logic clk_i, rst_ni;
  svpd_in_if #(.VOLT_WIDTH(VW)) in_if ();
  svpd_out_if out_if ();
  svpd_cfg_if cfg_if ();

  space_vector_pwm_duty_core #(.VOLT_WIDTH(VW)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_s(in_if.sink), .out_s(out_if.source),
    .cfg_s(cfg_if.sink)
  );

  // Expected result word: sector, compare values and phase voltages
  typedef struct {
    logic [2:0]  sector;
    logic [15:0] cmp [3];
    logic [15:0] volt[3];
  } duty_word_t;

  // Directed row: vector, optional typed-in sector/compare A/volt A
  typedef struct {
    logic signed [15:0] a, b;
    bit                 known;
    logic [2:0]         sec;
    logic [15:0]        cmp_a, volt_a;
  } vec_row_t;

  duty_word_t duty_q[$];
  logic [15:0] bus_v, period;
  int  mismatches, words_in, words_out, configs_done;
  bit  idle_off, out_hold;
  longint cycle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("FAIL space_vector_pwm_duty_core");
      $finish;
    end
  end

  function automatic int sector_pick(longint a, longint b);
    longint aa, bb;
    aa = a < 0 ? -a : a;
    bb = b < 0 ? -b : b;
    if (a == 0 && b == 0) return 0;
    if (3 * bb * bb < aa * aa) return a > 0 ? 0 : 3;
    if (b > 0) return a > 0 ? 1 : 2;
    return (a < 0) ? 4 : 5;
  endfunction

  // Round-half-up duty in Q1.15, clamped to 0..1.0; on a zero bus voltage it saturates by sign
  function automatic longint duty_q15(longint num, longint vdc);
    longint den, q, d;
    if (vdc == 0) return num > 0 ? 32768 : (num < 0 ? 0 : 16384);
    den = vdc * 3072;
    q = num + den / 2;
    q = (q >= 0) ? q / den : -((-q + den - 1) / den);
    d = 16384 + q;
    if (d < 0) d = 0;
    if (d > 32768) d = 32768;
    return d;
  endfunction

  function automatic duty_word_t svpwm_predict(logic signed [15:0] va,
                                               logic signed [15:0] vb);
    duty_word_t w;
    longint a, b, ua, uq, sum, d;
    longint u[3];
    int s;
    a  = va;
    b  = vb;
    ua = a <<< 24;
    uq = b * SQ3;
    s  = sector_pick(a, b);
    case (s)
      0: u = '{2 * ua, ua + uq, 0};
      1: u = '{ua - uq, 2 * uq, 0};
      2: u = '{0, ua + uq, -2 * ua};
      3: u = '{0, ua - uq, uq - ua};
      4: u = '{-2 * ua, 0, -ua - uq};
      default: u = '{uq - ua, 0, -2 * uq};
    endcase
    sum = u[0] + u[1] + u[2];
    w.sector = s[2:0];
    for (int i = 0; i < 3; i++) begin
      d = duty_q15(3 * u[i] - sum, longint'(bus_v));
      w.cmp[i]  = 16'((d * longint'(period) + 16384) >>> 15);
      w.volt[i] = 16'((d * longint'(bus_v)) >>> 15);
    end
    return w;
  endfunction

  function automatic bit idle_roll();
    return !idle_off && ($urandom_range(99) < 36);
  endfunction

  // valid stays up between back-to-back words; it drops only while idling or draining
  task automatic push_vector(logic signed [15:0] va, logic signed [15:0] vb);
    while (idle_roll()) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.v_alpha <= va;
    in_if.v_beta  <= vb;
    duty_q.push_back(svpwm_predict(va, vb));
    do @(posedge clk_i); while (!in_if.ready);
    words_in++;
  endtask

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_DC_BUS) bus_v = val;
    else period = val;
    configs_done++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (duty_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= !out_hold && !idle_roll();
  end

  // Result checker
  always @(posedge clk_i) begin
    duty_word_t e;
    bit bad;
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_out++;
      if (duty_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycle);
      end else begin
        e = duty_q.pop_front();
        bad = (out_if.sector !== e.sector) ||
              (out_if.compare_a !== e.cmp[0]) || (out_if.compare_b !== e.cmp[1]) ||
              (out_if.compare_c !== e.cmp[2]) ||
              (out_if.phase_volt_a !== e.volt[0]) ||
              (out_if.phase_volt_b !== e.volt[1]) ||
              (out_if.phase_volt_c !== e.volt[2]);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch word %0d: exp sec %0d cmp %0d %0d %0d volt %0d %0d %0d",
                     words_out, e.sector, e.cmp[0], e.cmp[1], e.cmp[2],
                     e.volt[0], e.volt[1], e.volt[2],
                     "\n    got sec %0d cmp %0d %0d %0d volt %0d %0d %0d",
                     out_if.sector, out_if.compare_a, out_if.compare_b,
                     out_if.compare_c, out_if.phase_volt_a,
                     out_if.phase_volt_b, out_if.phase_volt_c);
        end
      end
    end
  end

  // Directed table: extremes, both sector boundaries at +/-90 deg, near 30 deg, origin.
  // Typed-in values hold at reset registers (6144, 5000).
  vec_row_t dir_tab[] = '{
    '{16'sd0,      16'sd0,      1, 3'd0, 16'd2500, 16'd3072},   // origin: duty 0.5
    '{16'sd0,      16'sd100,    1, 3'd2, 16'd2477, 16'd3043},   // exactly +90 deg
    '{16'sd0,     -16'sd100,    0, 3'd5, 16'd0,    16'd0},      // exactly -90 deg
    '{16'sd32767,  16'sd0,      1, 3'd0, 16'd5000, 16'd6144},   // clamps high
    '{-16'sd32768, 16'sd0,      1, 3'd3, 16'd2500, 16'd3072},   // flat, phase A at half
    '{16'sd32767,  16'sd32767,  0, 0, 0, 0},
    '{-16'sd32768, -16'sd32768, 0, 0, 0, 0},
    '{16'sd32767, -16'sd32768,  0, 0, 0, 0},
    '{-16'sd32768, 16'sd32767,  0, 0, 0, 0},
    '{16'sd1000,   16'sd577,    0, 0, 0, 0},                   // near 30 deg
    '{16'sd1000,   16'sd578,    0, 0, 0, 0},
    '{-16'sd1000,  16'sd577,    0, 0, 0, 0},
    '{-16'sd1000, -16'sd578,    0, 0, 0, 0},
    '{16'sd1000,  -16'sd577,    0, 0, 0, 0},
    '{16'sd1,      16'sd0,      0, 0, 0, 0},
    '{-16'sd1,     16'sd1,      0, 0, 0, 0},
    '{16'sd2000,   16'sd1000,   0, 0, 0, 0},
    '{-16'sd2000, -16'sd3000,   0, 0, 0, 0}
  };

  initial begin
    logic signed [15:0] ra, rb;
    int m;
    rst_ni = 1'b0;
    cycle = 0; mismatches = 0; words_in = 0; words_out = 0; configs_done = 0;
    idle_off = 1'b0; out_hold = 1'b0;
    in_if.valid = 1'b0; in_if.v_alpha = '0; in_if.v_beta = '0;
    cfg_if.valid = 1'b0; cfg_if.index = REG_DC_BUS; cfg_if.data = '0;
    bus_v = VDC_RST; period = PERIOD_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; typed-in ones checked here as well as by the checker
    foreach (dir_tab[i]) begin
      if (dir_tab[i].known) begin
        duty_word_t w;
        w = svpwm_predict(dir_tab[i].a, dir_tab[i].b);
        if (w.sector !== dir_tab[i].sec || w.cmp[0] !== dir_tab[i].cmp_a ||
            w.volt[0] !== dir_tab[i].volt_a) begin
          mismatches++;
          if (mismatches <= 10) $display("table row %0d disagrees with prediction", i);
        end
      end
      push_vector(dir_tab[i].a, dir_tab[i].b);
    end
    drain();

    // Random phases across register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_DC_BUS, 16'd1); write_reg(REG_PWM_PERIOD, 16'd65535); end
        1: begin write_reg(REG_DC_BUS, 16'd65535); write_reg(REG_PWM_PERIOD, 16'd1); end
        2: begin write_reg(REG_DC_BUS, 16'd0); write_reg(REG_PWM_PERIOD, 16'd0); end
        default: begin
          write_reg(REG_DC_BUS, 16'($urandom_range(65535, 1)));
          write_reg(REG_PWM_PERIOD, 16'($urandom_range(65535, 1)));
        end
      endcase
      idle_off = (ph == 4);   // a stretch with no idling
      if (ph == 3) begin
        // long receiver hold-off while words keep coming: pipe fills, input stalls
        fork
          begin
            out_hold = 1'b1;
            repeat (60) @(posedge clk_i);
            out_hold = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < N_RANDOM / 6; k++) begin
        m = $urandom_range(3);
        // half realistic amplitudes, a quarter full-scale and a quarter tiny
        if (m == 0) begin ra = 16'($urandom); rb = 16'($urandom); end
        else if (m == 1) begin
          ra = 16'($signed($urandom_range(64)) - 32);
          rb = 16'($signed($urandom_range(64)) - 32);
        end else begin
          ra = 16'($signed($urandom_range(16000)) - 8000);
          rb = 16'($signed($urandom_range(16000)) - 8000);
        end
        push_vector(ra, rb);
        if (ph == 5 && k == 20) drain();   // sender pause until all arrive
      end
      drain();
    end
    idle_off = 1'b0;

    $display("covered %0d words in, %0d out, %0d register writes, incl. zero bus",
             words_in, words_out, configs_done);
    if (mismatches == 0 && duty_q.size() == 0) begin
      $display("PASS space_vector_pwm_duty_core");
    end else begin
      $display("FAIL space_vector_pwm_duty_core");
    end
    $finish;
  end
endmodule
